// File: rtl/ioapic_pkg.sv
// Shared types and constants for the I/O interrupt controller register window.
package ioapic_pkg;

	localparam int unsigned REDIRECT_WORDS_DEF = 48;

	// request types
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_INVALID     = 2'd1;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
	localparam logic [1:0] ST_ACCESS      = 2'd3;

	// bus offsets
	localparam logic [11:0] OFS_SELECT = 12'h000;
	localparam logic [11:0] OFS_WINDOW = 12'h010;

	// select values
	localparam logic [31:0] SEL_ID             = 32'h0000_0000;
	localparam logic [31:0] SEL_VERSION        = 32'h0000_0001;
	localparam logic [31:0] SEL_ARB            = 32'h0000_0002;
	localparam logic [31:0] SEL_FIRST_REDIRECT = 32'h0000_0010;
	localparam logic [31:0] SEL_MAX_VALID      = 32'h0000_00FF;

	localparam logic [31:0] VERSION_CODE = 32'h0000_0011;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] bus_offset;
		logic [31:0] write_data;
		logic        size_is_word;
		logic [4:0]  irq_index;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  status;
		logic [7:0]  vector;
	} rsp_t;

endpackage

// File: rtl/ioapic_redir_table.sv
// Redirect word table: one write port, one registered read port, per-entry valid bits.
module ioapic_redir_table #(
	parameter int unsigned DEPTH = ioapic_pkg::REDIRECT_WORDS_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	import ioapic_pkg::*;

	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [31:0]      rdata_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			hit_q <= valid_q[raddr];
		end
	end

	assign rdata = hit_q ? rdata_q : 32'h0;

endmodule

// File: rtl/io_apic_register_window.sv
// Top level of the I/O interrupt controller indirect register window.
// Usage: a word is taken on every clock edge where start is high; busy is never
// raised, so one request per cycle is sustained. Each request gives exactly one
// result on rsp, marked by a one-cycle done strobe once it has passed the input
// register, the registered table read and the result register. Results come in
// request order and cannot be stalled. The redirect table has one read port
// shared by window reads and vector queries, and one write port.
module io_apic_register_window #(
	parameter int unsigned REDIRECT_WORDS = ioapic_pkg::REDIRECT_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ioapic_pkg::req_t  req,
	output logic              done,
	output ioapic_pkg::rsp_t  rsp
);
	import ioapic_pkg::*;

	localparam int unsigned AW = $clog2(REDIRECT_WORDS);
	localparam logic [31:0] VERSION_WORD =
		(32'(REDIRECT_WORDS / 2 - 1) << 16) | VERSION_CODE;

	// stage 1: registered request
	logic        valid_s1;
	req_t        req_s1;

	// architectural registers
	logic [31:0] select_q;
	logic [31:0] id_q;

	// stage 2: decoded result awaiting table data
	logic        valid_s2;
	logic [1:0]  status_s2;
	logic [31:0] rd_fix_s2;
	logic        rd_mem_s2;
	logic        vec_mem_s2;

	// result register
	logic        done_q;
	rsp_t        rsp_q;

	// decode
	logic        is_write;
	logic        is_word;
	logic [31:0] sel_off;
	logic        sel_in_table;
	logic [5:0]  q_idx;
	logic        q_in_table;
	logic [1:0]  status_d;
	logic [31:0] rd_fix_d;
	logic        rd_mem_d;
	logic        vec_mem_d;
	logic        sel_we;
	logic        id_we;
	logic        tbl_we;
	logic [AW-1:0] tbl_raddr;
	logic [31:0] tbl_rdata;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= req;
		end
	end

	assign is_write     = (req_s1.req_type == REQ_WRITE);
	assign is_word      = req_s1.size_is_word;
	assign sel_off      = select_q - SEL_FIRST_REDIRECT;
	assign sel_in_table = (select_q >= SEL_FIRST_REDIRECT) &&
		(sel_off < 32'(REDIRECT_WORDS));
	assign q_idx        = {req_s1.irq_index, 1'b0};
	assign q_in_table   = (32'(q_idx) < 32'(REDIRECT_WORDS));

	always_comb begin
		status_d  = ST_OK;
		rd_fix_d  = 32'h0;
		rd_mem_d  = 1'b0;
		vec_mem_d = 1'b0;
		sel_we    = 1'b0;
		id_we     = 1'b0;
		tbl_we    = 1'b0;
		priority if (req_s1.req_type == REQ_QUERY) begin
			vec_mem_d = q_in_table;
		end else if (req_s1.req_type == REQ_NONE) begin
			status_d = ST_UNSUPPORTED;
		end else if (req_s1.bus_offset == OFS_SELECT) begin
			if (!is_write || !is_word) begin
				status_d = ST_ACCESS;
			end else begin
				sel_we   = 1'b1;
				status_d = (req_s1.write_data > SEL_MAX_VALID) ? ST_INVALID : ST_OK;
			end
		end else if (req_s1.bus_offset == OFS_WINDOW) begin
			priority if (select_q == SEL_ID) begin
				if (!is_word) begin
					status_d = ST_ACCESS;
				end else if (is_write) begin
					id_we = 1'b1;
				end else begin
					rd_fix_d = id_q;
				end
			end else if (select_q == SEL_VERSION) begin
				if (!is_word || is_write) begin
					status_d = ST_ACCESS;
				end else begin
					rd_fix_d = VERSION_WORD;
				end
			end else if (select_q == SEL_ARB) begin
				if (!is_word || is_write) begin
					status_d = ST_ACCESS;
				end
			end else if (sel_in_table) begin
				if (!is_word) begin
					status_d = ST_ACCESS;
				end else if (is_write) begin
					tbl_we = 1'b1;
				end else begin
					rd_mem_d = 1'b1;
				end
			end else begin
				status_d = ST_UNSUPPORTED;
			end
		end else begin
			status_d = ST_UNSUPPORTED;
		end
	end

	assign tbl_raddr = (req_s1.req_type == REQ_QUERY) ? AW'(q_idx) : AW'(sel_off);

	ioapic_redir_table #(
		.DEPTH(REDIRECT_WORDS)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (valid_s1 && tbl_we),
		.waddr (AW'(sel_off)),
		.wdata (req_s1.write_data),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q <= 32'h0;
			id_q     <= 32'h0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (valid_s1 && sel_we) begin
				select_q <= req_s1.write_data;
			end
			if (valid_s1 && id_we) begin
				id_q <= req_s1.write_data;
			end
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		status_s2  <= status_d;
		rd_fix_s2  <= rd_fix_d;
		rd_mem_s2  <= rd_mem_d;
		vec_mem_s2 <= vec_mem_d;
		rsp_q.read_data <= rd_mem_s2 ? tbl_rdata : rd_fix_s2;
		rsp_q.status    <= status_s2;
		rsp_q.vector    <= vec_mem_s2 ? tbl_rdata[7:0] : 8'h00;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result word without a matching request");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != ST_OK) |-> (rsp.read_data == 32'h0))
		else $error("read data returned with error status");

	a_vec_query: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.vector != 8'h00) |-> (rsp.status == ST_OK) && (rsp.read_data == 32'h0))
		else $error("vector returned outside a query");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $countones({sel_we, id_we, tbl_we}) <= 1)
		else $error("more than one register written by one request");

	a_tbl_sel: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && tbl_we |=> $stable(select_q) && $stable(id_q))
		else $error("select or ID changed by a table write");
`endif

endmodule
